FILE: sv/frame_beat_grid_convert_defines.svh
// Assertion macros shared by the frame and beat grid converter.
`ifndef FRAME_BEAT_GRID_CONVERT_DEFINES_SVH
`define FRAME_BEAT_GRID_CONVERT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FBGC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FBGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fbgc_pkg.sv
// Shared widths, register indexes and stage types of the frame and beat grid converter.
package fbgc_pkg;

  localparam int FRAME_W  = 31;
  localparam int BEAT_W   = 32;
  localparam int RES_W    = 64;
  localparam int RATIO_W  = 40;
  localparam int MAG_W    = 32;
  localparam int HALF_W   = RATIO_W / 2;
  localparam int PP_W     = MAG_W + HALF_W;
  localparam int NUM_W    = 72;
  localparam int REM_W    = RATIO_W;
  localparam int CFG_DW   = 64;
  localparam int CFG_AW   = 5;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_ORIGIN = 2'd0;
  localparam logic [IDX_W-1:0] REG_NUM    = 2'd1;
  localparam logic [IDX_W-1:0] REG_DEN    = 2'd2;

  localparam logic [RES_W-1:0] BEAT_MAX = {1'b0, {(RES_W-1){1'b1}}};

  typedef struct packed {
    logic kind;
    logic neg;
  } tag_t;

  typedef struct packed {
    logic             valid;
    tag_t             tag;
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } link_t;

endpackage

FILE: sv/fbgc_in_if.sv
// Input channel of the converter: one conversion request per beat.
interface fbgc_in_if;
  import fbgc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic signed [FRAME_W-1:0] frame_pos;
  logic signed [BEAT_W-1:0]  beat_index;

  modport source(output valid, output kind, output frame_pos, output beat_index,
                 input ready);
  modport sink(input valid, input kind, input frame_pos, input beat_index,
               output ready);
endinterface

FILE: sv/fbgc_out_if.sv
// Result channel of the converter: one converted value per beat.
interface fbgc_out_if;
  import fbgc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic                    invalid;

  modport source(output valid, output result_value, output invalid, input ready);
  modport sink(input valid, input result_value, input invalid, output ready);
endinterface

FILE: sv/fbgc_front.sv
// Operand stage and split multiplier that build the dividend for the divider chain.
module fbgc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          up_valid,
  output logic                          up_take,
  input  logic                          kind,
  input  logic [fbgc_pkg::FRAME_W-1:0]  frame_pos,
  input  logic [fbgc_pkg::BEAT_W-1:0]   beat_index,
  input  logic [fbgc_pkg::FRAME_W-1:0]  origin,
  input  logic [fbgc_pkg::RATIO_W-1:0]  num,
  input  logic [fbgc_pkg::RATIO_W-1:0]  den,
  input  logic                          dn_take,
  output fbgc_pkg::link_t               dn
);
  import fbgc_pkg::*;

  logic                 va_r, va_nxt, vb_r, vb_nxt, vc_r, vc_nxt;
  logic                 take_a, take_b, take_c;
  tag_t                 tag_a_r, tag_a_nxt, tag_b_r, tag_c_r;
  logic [MAG_W-1:0]     mag_a_r, mag_a_nxt;
  logic [PP_W-1:0]      plo_b_r, plo_b_nxt, phi_b_r, phi_b_nxt;
  logic [NUM_W-1:0]     numer_c_r, numer_c_nxt;
  logic [MAG_W-1:0]     offset;
  logic [RATIO_W-1:0]   mulop;
  logic [NUM_W-1:0]     addend;

  assign take_a  = adv || !va_r;
  assign take_b  = adv || !vb_r;
  assign take_c  = adv || !vc_r;
  assign up_take = take_a;

  assign va_nxt = take_a ? up_valid : (take_b ? 1'b0 : va_r);
  assign vb_nxt = take_b ? va_r : (take_c ? 1'b0 : vb_r);
  assign vc_nxt = take_c ? vb_r : (dn_take ? 1'b0 : vc_r);

  always_comb begin
    offset = {frame_pos[FRAME_W-1], frame_pos} - {origin[FRAME_W-1], origin};
    tag_a_nxt.kind = kind;
    if (kind) begin
      tag_a_nxt.neg = beat_index[BEAT_W-1];
      mag_a_nxt = tag_a_nxt.neg ? (MAG_W'(0) - beat_index) : beat_index;
    end else begin
      tag_a_nxt.neg = offset[MAG_W-1];
      mag_a_nxt = tag_a_nxt.neg ? ~offset : offset;
    end
  end

  always_comb begin
    mulop     = tag_a_r.kind ? num : den;
    plo_b_nxt = mag_a_r * mulop[HALF_W-1:0];
    phi_b_nxt = mag_a_r * mulop[RATIO_W-1:HALF_W];
  end

  always_comb begin
    addend      = tag_b_r.kind ? NUM_W'(den - RATIO_W'(1)) : '0;
    numer_c_nxt = NUM_W'(plo_b_r) + {phi_b_r, {HALF_W{1'b0}}} + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_a) begin
      tag_a_r <= tag_a_nxt;
      mag_a_r <= mag_a_nxt;
    end
    if (take_b) begin
      tag_b_r <= tag_a_r;
      plo_b_r <= plo_b_nxt;
      phi_b_r <= phi_b_nxt;
    end
    if (take_c) begin
      tag_c_r   <= tag_b_r;
      numer_c_r <= numer_c_nxt;
    end
  end

  assign dn.valid = vc_r;
  assign dn.tag   = tag_c_r;
  assign dn.rem   = '0;
  assign dn.nq    = numer_c_r;
endmodule

FILE: sv/fbgc_div_cell.sv
// One restoring division cell that settles one quotient bit and passes it on.
module fbgc_div_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  fbgc_pkg::link_t              up,
  output logic                         take,
  input  logic                         dn_take,
  input  logic [fbgc_pkg::RATIO_W-1:0] num,
  input  logic [fbgc_pkg::RATIO_W-1:0] den,
  output fbgc_pkg::link_t              dn
);
  import fbgc_pkg::*;

  logic               valid_r, valid_nxt;
  tag_t               tag_r;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0]   nq_r, nq_nxt;
  logic [RATIO_W-1:0] divisor;
  logic [REM_W:0]     trial, diff;
  logic               ge;

  assign take      = adv || !valid_r;
  assign valid_nxt = take ? up.valid : (dn_take ? 1'b0 : valid_r);

  always_comb begin
    divisor = up.tag.kind ? den : num;
    trial   = {up.rem, up.nq[NUM_W-1]};
    diff    = trial - {1'b0, divisor};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    nq_nxt  = {up.nq[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag_r <= up.tag;
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign dn.valid = valid_r;
  assign dn.tag   = tag_r;
  assign dn.rem   = rem_r;
  assign dn.nq    = nq_r;
endmodule

FILE: sv/fbgc_back.sv
// Result formatting and output register: saturation, sign handling and origin offset.
module fbgc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fbgc_pkg::link_t              up,
  input  logic [fbgc_pkg::FRAME_W-1:0] origin,
  input  logic [fbgc_pkg::RATIO_W-1:0] num,
  input  logic [fbgc_pkg::RATIO_W-1:0] den,
  input  logic                         out_ready,
  output logic                         adv,
  output logic                         out_valid,
  output logic [fbgc_pkg::RES_W-1:0]   out_value,
  output logic                         out_invalid
);
  import fbgc_pkg::*;

  logic              valid_r, valid_nxt;
  logic [RES_W-1:0]  value_r, value_nxt;
  logic              inv_r, inv_nxt;
  logic              sat;
  logic [RES_W-1:0]  beats, fval, bval;
  logic [BEAT_W-1:0] low, fsum;

  assign adv       = !valid_r || out_ready;
  assign valid_nxt = adv ? up.valid : valid_r;

  always_comb begin
    sat       = |up.nq[NUM_W-1:RES_W-1];
    beats     = sat ? BEAT_MAX : up.nq[RES_W-1:0];
    fval      = up.tag.neg ? ~beats : beats;
    low       = up.tag.neg ? (BEAT_W'(0) - up.nq[BEAT_W-1:0]) : up.nq[BEAT_W-1:0];
    fsum      = low + {origin[FRAME_W-1], origin};
    bval      = {{(RES_W-BEAT_W){fsum[BEAT_W-1]}}, fsum};
    inv_nxt   = (num == '0) || (den == '0);
    value_nxt = inv_nxt ? '0 : (up.tag.kind ? bval : fval);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_nxt;
      inv_r   <= inv_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_value   = value_r;
  assign out_invalid = inv_r;
endmodule

FILE: sv/frame_beat_grid_convert.sv
// Top level of the frame and beat grid converter with its register port and divider chain.
// An accepted input beat passes the front stages, the divider chain and the output stage.
// Throughput: one conversion per cycle unless the output stalls, set by the 72 restoring
// division cells each settling one quotient bit, behind a split 32 by 20 bit multiplier.
// A stalled output holds the chain; empty stages still fill, so bubbles close up.
// Reset clears all valid bits and sets origin_frame, frames_num and frames_den to zero.
module frame_beat_grid_convert (
  input  logic                        clk,
  input  logic                        rst_n,
  fbgc_in_if.sink                     in_bus,
  fbgc_out_if.source                  out_bus,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [fbgc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fbgc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fbgc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import fbgc_pkg::*;

  `include "frame_beat_grid_convert_defines.svh"

  logic [FRAME_W-1:0] origin_frame_r, origin_frame_nxt;
  logic [RATIO_W-1:0] frames_num_r, frames_num_nxt;
  logic [RATIO_W-1:0] frames_den_r, frames_den_nxt;
  logic [IDX_W-1:0]   reg_idx;
  logic               cfg_wr;
  logic               adv;
  logic [RES_W-1:0]   out_value;
  link_t              lnk [0:NUM_W];
  logic               take [0:NUM_W];

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_AW-1:CFG_AW-IDX_W];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    origin_frame_nxt = origin_frame_r;
    frames_num_nxt   = frames_num_r;
    frames_den_nxt   = frames_den_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN: begin
          origin_frame_nxt = cfg_pwdata[FRAME_W-1:0];
        end
        REG_NUM: begin
          frames_num_nxt = cfg_pwdata[RATIO_W-1:0];
        end
        REG_DEN: begin
          frames_den_nxt = cfg_pwdata[RATIO_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN: begin
        cfg_prdata = {{(CFG_DW-FRAME_W){origin_frame_r[FRAME_W-1]}}, origin_frame_r};
      end
      REG_NUM: begin
        cfg_prdata = CFG_DW'(frames_num_r);
      end
      REG_DEN: begin
        cfg_prdata = CFG_DW'(frames_den_r);
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_frame_r <= '0;
      frames_num_r   <= '0;
      frames_den_r   <= '0;
    end else begin
      origin_frame_r <= origin_frame_nxt;
      frames_num_r   <= frames_num_nxt;
      frames_den_r   <= frames_den_nxt;
    end
  end

  fbgc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .up_valid   (in_bus.valid),
    .up_take    (in_bus.ready),
    .kind       (in_bus.kind),
    .frame_pos  (in_bus.frame_pos),
    .beat_index (in_bus.beat_index),
    .origin     (origin_frame_r),
    .num        (frames_num_r),
    .den        (frames_den_r),
    .dn_take    (take[0]),
    .dn         (lnk[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    fbgc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .up      (lnk[i]),
      .take    (take[i]),
      .dn_take (take[i+1]),
      .num     (frames_num_r),
      .den     (frames_den_r),
      .dn      (lnk[i+1])
    );
  end

  assign take[NUM_W] = adv;

  fbgc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .up          (lnk[NUM_W]),
    .origin      (origin_frame_r),
    .num         (frames_num_r),
    .den         (frames_den_r),
    .out_ready   (out_bus.ready),
    .adv         (adv),
    .out_valid   (out_bus.valid),
    .out_value   (out_value),
    .out_invalid (out_bus.invalid)
  );

  assign out_bus.result_value = out_value;

  `FBGC_ASSERT_SAME(a_invalid_zero, out_bus.valid && out_bus.invalid, out_value == '0, "Invalid result beat carries a nonzero value.")
  `FBGC_ASSERT_NEXT(a_last_cell_hold, lnk[NUM_W].valid && !adv, lnk[NUM_W].valid && $stable(lnk[NUM_W].nq), "Last division cell lost or changed its beat while stalled.")
  `FBGC_ASSERT_NEXT(a_stall_keeps_output, !adv, out_bus.valid, "Output beat dropped while the chain was stalled.")
endmodule

FILE: test/tb.sv
// Self-checking testbench of the frame and beat grid converter with its own conversion model.
`timescale 1ns / 1ps

module tb;
  import fbgc_pkg::*;

  localparam logic signed [FRAME_W-1:0] FRAME_MIN = FRAME_W'(-(2 ** 30));
  localparam logic signed [FRAME_W-1:0] FRAME_MAX = FRAME_W'(2 ** 30 - 1);
  localparam logic signed [BEAT_W-1:0]  BEAT_MIN  = 32'sh8000_0000;
  localparam logic signed [BEAT_W-1:0]  BEAT_MAX_IDX = 32'sh7FFF_FFFF;
  localparam logic [RATIO_W-1:0]        RATIO_MAX = {RATIO_W{1'b1}};
  localparam int PHASE_BEATS = 135;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    invalid;
  } conv_result_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  logic signed [FRAME_W-1:0] origin_q;
  logic [RATIO_W-1:0] num_q;
  logic [RATIO_W-1:0] den_q;
  conv_result_t pending_results[$];
  int error_count;
  int send_idle_pct;
  int recv_stall_pct;

  fbgc_in_if in_if ();
  fbgc_out_if out_if ();

  frame_beat_grid_convert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_if),
    .out_bus    (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("FAIL frame_beat_grid_convert");
    $finish;
  end

  function automatic conv_result_t grid_convert(input logic k, input logic signed [FRAME_W-1:0] f,
                                                input logic signed [BEAT_W-1:0] b);
    conv_result_t r;
    logic signed [32:0] fx;
    logic signed [32:0] ox;
    logic signed [32:0] offset;
    logic signed [32:0] bx;
    logic [32:0] m33;
    logic [127:0] quo;
    logic [RES_W-1:0] beats;
    logic [31:0] low;
    logic neg;
    r.value = '0;
    r.invalid = 1'b0;
    if (num_q == '0 || den_q == '0) begin
      r.invalid = 1'b1;
      return r;
    end
    if (!k) begin
      fx = f;
      ox = origin_q;
      offset = fx - ox;
      neg = offset[32];
      m33 = neg ? ~offset : offset;
      quo = ({95'd0, m33} * {88'd0, den_q}) / {88'd0, num_q};
      beats = (quo > {64'd0, BEAT_MAX}) ? BEAT_MAX : quo[63:0];
      r.value = neg ? ~beats : beats;
    end else begin
      bx = b;
      neg = b[31];
      m33 = neg ? -bx : bx;
      quo = ({95'd0, m33} * {88'd0, num_q} + {88'd0, den_q} - 128'd1) / {88'd0, den_q};
      low = quo[31:0];
      if (neg) low = 32'd0 - low;
      low = low + {origin_q[FRAME_W-1], origin_q};
      r.value = {{32{low[31]}}, low};
    end
    return r;
  endfunction

  function automatic logic [RATIO_W-1:0] pick_ratio();
    logic [63:0] raw;
    logic [RATIO_W-1:0] v;
    int bits;
    raw = {$urandom, $urandom};
    bits = $urandom_range(1, RATIO_W);
    if ($urandom_range(0, 15) == 0) return '0;
    v = raw[RATIO_W-1:0] & ((40'd1 << bits) - 40'd1);
    return (v == '0) ? 40'd1 : v;
  endfunction

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    conv_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        if (error_count < 10)
          $display("unexpected beat: value %0d invalid %0b",
                   out_if.result_value, out_if.invalid);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.value !== out_if.result_value || want.invalid !== out_if.invalid) begin
          if (error_count < 10)
            $display("mismatch: expected value %0d invalid %0b, got value %0d invalid %0b",
                     want.value, want.invalid, out_if.result_value, out_if.invalid);
          error_count++;
        end
      end
    end
  end

  task automatic send_conv(input logic k, input logic signed [FRAME_W-1:0] f,
                           input logic signed [BEAT_W-1:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.kind <= k;
    in_if.frame_pos <= f;
    in_if.beat_index <= b;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(grid_convert(k, f, b));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_ORIGIN: origin_q = value[FRAME_W-1:0];
      REG_NUM:    num_q = value[RATIO_W-1:0];
      REG_DEN:    den_q = value[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic signed [FRAME_W-1:0] origin,
                          input logic [RATIO_W-1:0] num, input logic [RATIO_W-1:0] den);
    wait_drained();
    set_reg(REG_ORIGIN, {{(CFG_DW - FRAME_W){origin[FRAME_W-1]}}, origin});
    set_reg(REG_NUM, {24'd0, num});
    set_reg(REG_DEN, {24'd0, den});
  endtask

  task automatic send_random_item();
    logic signed [FRAME_W-1:0] f;
    logic signed [BEAT_W-1:0] b;
    logic k;
    k = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: f = $urandom_range(0, 1) ? FRAME_MIN : FRAME_MAX;
      1: f = origin_q + FRAME_W'(int'($urandom_range(0, 600)) - 300);
      default: f = FRAME_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: b = $urandom_range(0, 1) ? BEAT_MIN : BEAT_MAX_IDX;
      1, 2: b = int'($urandom_range(0, 2000)) - 1000;
      default: b = $urandom;
    endcase
    send_conv(k, f, b);
  endtask

  task automatic test_zero_ratio();
    send_conv(1'b0, FRAME_MAX, BEAT_MIN);
    send_conv(1'b1, FRAME_MIN, BEAT_MAX_IDX);
    wait_drained();
    set_reg(REG_NUM, 64'd3);
    send_conv(1'b0, 31'sd12, 32'sd0);
    send_conv(1'b1, 31'sd0, 32'sd12);
    set_grid(-31'sd5, '0, 40'd5);
    send_conv(1'b0, -31'sd12, -32'sd1);
    send_conv(1'b1, 31'sd0, -32'sd12);
  endtask

  task automatic test_field_extremes();
    set_grid(-31'sd5, 40'd7, 40'd3);
    send_conv(1'b0, FRAME_MIN, $urandom);
    send_conv(1'b0, FRAME_MAX, $urandom);
    send_conv(1'b0, 31'sd0, $urandom);
    send_conv(1'b0, -31'sd1, $urandom);
    send_conv(1'b1, FRAME_W'($urandom), BEAT_MIN);
    send_conv(1'b1, FRAME_W'($urandom), BEAT_MAX_IDX);
    send_conv(1'b1, FRAME_W'($urandom), 32'sd0);
    send_conv(1'b1, FRAME_W'($urandom), -32'sd1);
  endtask

  task automatic test_overflow();
    set_grid(FRAME_MIN, 40'd1, RATIO_MAX);
    send_conv(1'b0, FRAME_MAX, 32'sd0);
    wait_drained();
    set_reg(REG_ORIGIN, {{(CFG_DW - FRAME_W){FRAME_MAX[FRAME_W-1]}}, FRAME_MAX});
    send_conv(1'b0, FRAME_MIN, 32'sd0);
    set_grid(31'sd0, RATIO_MAX, 40'd1);
    send_conv(1'b1, 31'sd0, BEAT_MAX_IDX);
    send_conv(1'b1, 31'sd0, BEAT_MIN);
  endtask

  task automatic test_random_grids();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_grid(FRAME_MIN, RATIO_MAX, RATIO_MAX);
        1: set_grid(FRAME_MAX, 40'd1, 40'd1);
        2: set_grid(31'sd0, RATIO_MAX, 40'd1);
        3: set_grid(FRAME_W'($urandom), 40'd1, RATIO_MAX);
        default: set_grid(FRAME_W'($urandom), pick_ratio(), pick_ratio());
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase % 3 == 1 && n == PHASE_BEATS / 2) wait_drained();
        send_random_item();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.frame_pos = '0;
    in_if.beat_index = '0;
    out_if.ready = 1'b0;
    origin_q = '0;
    num_q = '0;
    den_q = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_ratio();
    test_field_extremes();
    test_overflow();
    test_random_grids();
    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS frame_beat_grid_convert");
    end else begin
      $display("FAIL frame_beat_grid_convert");
    end
    $finish;
  end

endmodule
